[rtl/assert_macros.svh]
// Assertion macros for the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication check, disabled during reset
`define ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication check, disabled during reset
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[rtl/sir_pkg.sv]
// ----------------------------------------------------------------------------
// sir_pkg
// Types and constants of the ratio scaler.
// ----------------------------------------------------------------------------
package sir_pkg;

    localparam int ValW   = 64;
    localparam int RatW   = 32;
    localparam int ProdW  = ValW + RatW;
    localparam int RemW   = RatW;
    localparam int Stages = ProdW;
    localparam int IdxW   = 1;

    localparam logic [IdxW-1:0] REG_NUM = 1'b0;
    localparam logic [IdxW-1:0] REG_DEN = 1'b1;

    localparam logic [ValW-1:0] SENTINEL = {1'b0, {(ValW-1){1'b1}}};
    localparam logic [ValW-1:0] MIN_MAG  = {1'b1, {(ValW-1){1'b0}}};

    // Data moving down the divider chain
    typedef struct packed {
        logic             vld;
        logic [ProdW-1:0] quo;
        logic [RemW:0]    rem;
        logic [RatW-1:0]  den;
        logic             neg;
        logic             dz;
    } cell_t;

endpackage

[rtl/sir_stream_if.sv]
// ----------------------------------------------------------------------------
// sir_stream_if
// Valid/ready stream channel with a generic payload.
// ----------------------------------------------------------------------------
interface sir_stream_if #(
    parameter int W = 64
);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

[rtl/scale_int64_by_ratio_core.sv]
// Pipeline: 2 multiply stages, 96 divider cells, 1 output register.
// Throughput: one item per cycle unless the output is stalled;
// one divider cell per quotient bit.
// An output stall freezes the whole chain.
// Reset: ratio registers return to 1/1, all pipeline valids clear.
// ----------------------------------------------------------------------------
// scale_int64_by_ratio_core
// Signed 64-bit value times unsigned 32/32 ratio, floored.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module scale_int64_by_ratio_core (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [sir_pkg::IdxW-1:0]   cfg_index,
    input  logic [sir_pkg::RatW-1:0]   cfg_data,
    sir_stream_if.sink                 sample,
    sir_stream_if.source               scaled
);
    logic [sir_pkg::RatW-1:0] num_reg;
    logic [sir_pkg::RatW-1:0] den_reg;
    logic en;
    logic out_vld_reg;
    logic [sir_pkg::ValW-1:0] out_val_reg;
    logic out_ovf_reg;

    // stall the chain only when a held result is not taken
    assign en = !out_vld_reg || scaled.ready;
    assign sample.ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_reg <= sir_pkg::RatW'(1);
            den_reg <= sir_pkg::RatW'(1);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                sir_pkg::REG_NUM: num_reg <= cfg_data;
                sir_pkg::REG_DEN: den_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // stage 1: magnitude, two partial products
    logic s1_vld_reg, s1_neg_reg;
    logic [sir_pkg::ValW-1:0] s1_hi_reg, s1_lo_reg;
    logic [sir_pkg::ValW-1:0] mag;
    assign mag = sample.data[sir_pkg::ValW-1] ? (~sample.data + 1'b1) : sample.data;

    // stage 2: 96-bit product
    logic s2_vld_reg, s2_neg_reg;
    logic [sir_pkg::ProdW-1:0] s2_prod_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_vld_reg <= sample.valid;
            s2_vld_reg <= s1_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_neg_reg  <= sample.data[sir_pkg::ValW-1];
            s1_hi_reg   <= num_reg * mag[sir_pkg::ValW-1:sir_pkg::RatW];
            s1_lo_reg   <= num_reg * mag[sir_pkg::RatW-1:0];
            s2_neg_reg  <= s1_neg_reg;
            s2_prod_reg <= {s1_hi_reg, {sir_pkg::RatW{1'b0}}}
                           + {{sir_pkg::RatW{1'b0}}, s1_lo_reg};
        end
    end

    // divider chain
    sir_pkg::cell_t chain [0:sir_pkg::Stages];
    always_comb
    begin
        chain[0].vld = s2_vld_reg;
        chain[0].quo = s2_prod_reg;
        chain[0].rem = '0;
        chain[0].den = den_reg;
        chain[0].neg = s2_neg_reg;
        chain[0].dz  = (den_reg == '0);
    end

    genvar g;
    generate
        for (g = 0; g < sir_pkg::Stages; g++)
        begin : g_cell
            sir_div_cell u_cell (
                .clk  (clk),
                .rst_n(rst_n),
                .en   (en),
                .prev (chain[g]),
                .cur  (chain[g+1])
            );
        end
    endgenerate

    // finish: round, range check, sign
    sir_pkg::cell_t fin;
    logic [sir_pkg::ValW:0] m_up;
    logic [sir_pkg::ValW-1:0] res;
    logic ovf;
    assign fin = chain[sir_pkg::Stages];

    always_comb
    begin
        m_up = {1'b0, fin.quo[sir_pkg::ValW-1:0]}
               + {{sir_pkg::ValW{1'b0}}, (fin.neg && fin.rem != '0)};
        ovf = fin.dz || (fin.quo[sir_pkg::ProdW-1:sir_pkg::ValW] != '0);
        res = sir_pkg::SENTINEL;
        if (fin.neg)
        begin
            if (m_up > {1'b0, sir_pkg::MIN_MAG})
                ovf = 1'b1;
            else
                res = ~m_up[sir_pkg::ValW-1:0] + 1'b1;
        end
        else
        begin
            if (m_up > {1'b0, sir_pkg::SENTINEL})
                ovf = 1'b1;
            else
                res = m_up[sir_pkg::ValW-1:0];
        end
        if (ovf)
            res = sir_pkg::SENTINEL;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (en)
            out_vld_reg <= fin.vld;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_val_reg <= res;
            out_ovf_reg <= ovf;
        end
    end

    assign scaled.valid = out_vld_reg;
    assign scaled.data  = {out_ovf_reg, out_val_reg};

    `ASSERT_IMPL(a_ovf_sentinel, scaled.valid && scaled.data[sir_pkg::ValW],
        scaled.data[sir_pkg::ValW-1:0] == sir_pkg::SENTINEL)
    `ASSERT_NEXT(a_hold, scaled.valid && !scaled.ready,
        scaled.valid && $stable(scaled.data))
    `ASSERT_IMPL(a_ready, scaled.valid && !scaled.ready, !sample.ready)
endmodule

[rtl/sir_div_cell.sv]
// ----------------------------------------------------------------------------
// sir_div_cell
// One restoring division step: shifts in one dividend bit, yields one
// quotient bit.
// ----------------------------------------------------------------------------
module sir_div_cell (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           en,
    input  sir_pkg::cell_t prev,
    output sir_pkg::cell_t cur
);
    sir_pkg::cell_t cur_next;
    logic [sir_pkg::RemW:0] trial;

    always_comb
    begin
        // shift partial remainder left, bring in next quotient/dividend bit
        trial = {prev.rem[sir_pkg::RemW-1:0], prev.quo[sir_pkg::ProdW-1]};
        cur_next = prev;
        cur_next.quo = {prev.quo[sir_pkg::ProdW-2:0], 1'b0};
        if (trial >= {1'b0, prev.den})
        begin
            cur_next.rem = trial - {1'b0, prev.den};
            cur_next.quo[0] = 1'b1;
        end
        else
        begin
            cur_next.rem = trial;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cur <= '0;
        else if (en)
            cur <= cur_next;
    end
endmodule
